@@ rtl/core/gpcd_pkg.sv @@
// Package for the grid pointer cycle detector: sizes, codes and the structs
// that pass between the loader, the walker and the top level.
// No dependencies.
package gpcd_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int DEPTH    = MAX_ROWS * MAX_COLS;
  localparam int AW       = $clog2(DEPTH);
  localparam int PW       = $clog2(DEPTH + 1);
  localparam int CW       = 7;
  localparam int DW       = 3;

  localparam logic [DW-1:0] DIR_LEFT  = 3'd0;
  localparam logic [DW-1:0] DIR_RIGHT = 3'd1;
  localparam logic [DW-1:0] DIR_UP    = 3'd2;
  localparam logic [DW-1:0] DIR_DOWN  = 3'd3;

  localparam logic CFG_ROW_COUNT    = 1'b0;
  localparam logic CFG_COLUMN_COUNT = 1'b1;

  localparam logic [1:0] COLOR_FREE     = 2'd0;
  localparam logic [1:0] COLOR_VISITING = 2'd1;
  localparam logic [1:0] COLOR_DONE     = 2'd2;

  typedef struct packed {
    logic          accept;
    logic          last;
    logic [DW-1:0] direction;
  } gpcd_load_t;

  typedef struct packed {
    logic          launch;
    logic [CW-1:0] rows;
    logic [CW-1:0] cols;
  } gpcd_launch_t;

  typedef struct packed {
    logic valid;
    logic has_cycle;
  } gpcd_result_t;

endpackage

@@ rtl/core/gpcd_dir_store.sv @@
// Direction store of the cycle detector: takes cells in row-major order and
// serves the walker's reads from a registered read port. Depends on gpcd_pkg.
module gpcd_dir_store (
  input  logic                   clk,
  input  logic                   rst_n,
  input  gpcd_pkg::gpcd_load_t   load,
  input  logic [gpcd_pkg::AW-1:0] rd_addr,
  output logic [gpcd_pkg::DW-1:0] rd_data
);
  import gpcd_pkg::*;

  logic [DW-1:0] mem [DEPTH];
  logic [PW-1:0] load_pos_r;
  logic [PW-1:0] load_pos_nxt;
  logic          load_we;

  // Cells beyond the store depth are dropped and the position holds.
  assign load_we = load.accept && (load_pos_r < PW'(DEPTH));

  always_comb begin
    load_pos_nxt = load_pos_r;
    if (load.accept) begin
      if (load.last) begin
        load_pos_nxt = '0;
      end else if (load_we) begin
        load_pos_nxt = load_pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_pos_r <= '0;
    end else begin
      load_pos_r <= load_pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_we) begin
      mem[load_pos_r[AW-1:0]] <= load.direction;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/core/gpcd_walker.sv @@
// Detection engine: owns the color store, clears it per grid, scans the cells
// and walks the pointer chains with read-modify-write on the color memory.
// Depends on gpcd_pkg; reads directions through the gpcd_dir_store port.
module gpcd_walker (
  input  logic                    clk,
  input  logic                    rst_n,
  input  gpcd_pkg::gpcd_launch_t  launch,
  input  logic [gpcd_pkg::DW-1:0] dir_q,
  output logic [gpcd_pkg::AW-1:0] rd_addr,
  output logic                    busy,
  output gpcd_pkg::gpcd_result_t  result
);
  import gpcd_pkg::*;

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_PREP      = 3'd1;
  localparam logic [2:0] S_TOTAL     = 3'd2;
  localparam logic [2:0] S_CLEAR     = 3'd3;
  localparam logic [2:0] S_SCAN      = 3'd4;
  localparam logic [2:0] S_WALK      = 3'd5;
  localparam logic [2:0] S_REWALK_RD = 3'd6;
  localparam logic [2:0] S_REWALK    = 3'd7;

  logic [1:0]    color_mem [DEPTH];
  logic [1:0]    color_q;
  logic          color_we;
  logic [AW-1:0] color_wa;
  logic [1:0]    color_wd;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] rows_r, rows_nxt, cols_r, cols_nxt;
  logic [PW-1:0] total_r, total_nxt;
  logic [PW-1:0] scan_r, scan_nxt;
  logic [CW-1:0] scan_row_r, scan_row_nxt, scan_col_r, scan_col_nxt;
  logic [CW-1:0] walk_row_r, walk_row_nxt, walk_col_r, walk_col_nxt;
  logic [AW-1:0] walk_idx_r, walk_idx_nxt;
  logic          first_r, first_nxt;
  logic          res_valid_r, res_valid_nxt;
  logic          res_cycle_r, res_cycle_nxt;

  logic [2*CW-1:0] prod;
  logic [PW-1:0]   scan_inc;
  logic            scan_last;
  logic [CW-1:0]   scan_row_inc, scan_col_inc;
  logic            scan_row_end;

  logic            step_ok;
  logic [CW-1:0]   step_row, step_col;
  logic [AW-1:0]   step_idx;

  assign prod         = rows_r * cols_r;
  assign scan_inc     = scan_r + 1'b1;
  assign scan_last    = (scan_inc == total_r);
  assign scan_row_inc = scan_row_r + 1'b1;
  assign scan_col_inc = scan_col_r + 1'b1;
  assign scan_row_end = (scan_col_inc == cols_r);

  // One pointer step from the current walk position.
  always_comb begin
    step_ok  = 1'b0;
    step_row = walk_row_r;
    step_col = walk_col_r;
    step_idx = walk_idx_r;
    unique case (dir_q)
      DIR_LEFT: begin
        step_ok  = (walk_col_r != '0);
        step_col = walk_col_r - 1'b1;
        step_idx = walk_idx_r - 1'b1;
      end
      DIR_RIGHT: begin
        step_ok  = ({1'b0, walk_col_r} + 1'b1) < {1'b0, cols_r};
        step_col = walk_col_r + 1'b1;
        step_idx = walk_idx_r + 1'b1;
      end
      DIR_UP: begin
        step_ok  = (walk_row_r != '0);
        step_row = walk_row_r - 1'b1;
        step_idx = walk_idx_r - AW'(cols_r);
      end
      DIR_DOWN: begin
        step_ok  = ({1'b0, walk_row_r} + 1'b1) < {1'b0, rows_r};
        step_row = walk_row_r + 1'b1;
        step_idx = walk_idx_r + AW'(cols_r);
      end
      default: begin
        step_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    rows_nxt      = rows_r;
    cols_nxt      = cols_r;
    total_nxt     = total_r;
    scan_nxt      = scan_r;
    scan_row_nxt  = scan_row_r;
    scan_col_nxt  = scan_col_r;
    walk_row_nxt  = walk_row_r;
    walk_col_nxt  = walk_col_r;
    walk_idx_nxt  = walk_idx_r;
    first_nxt     = first_r;
    res_valid_nxt = 1'b0;
    res_cycle_nxt = res_cycle_r;
    color_we      = 1'b0;
    color_wa      = walk_idx_r;
    color_wd      = COLOR_FREE;
    rd_addr       = walk_idx_r;

    unique case (state_r)
      S_IDLE: begin
        if (launch.launch) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        rows_nxt  = (int'(launch.rows) > MAX_ROWS) ? CW'(MAX_ROWS) : launch.rows;
        cols_nxt  = (int'(launch.cols) > MAX_COLS) ? CW'(MAX_COLS) : launch.cols;
        state_nxt = S_TOTAL;
      end
      S_TOTAL: begin
        total_nxt = PW'(prod);
        scan_nxt  = '0;
        if (rows_r == '0 || cols_r == '0) begin
          res_valid_nxt = 1'b1;
          res_cycle_nxt = 1'b0;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_CLEAR;
        end
      end
      S_CLEAR: begin
        color_we = 1'b1;
        color_wa = scan_r[AW-1:0];
        color_wd = COLOR_FREE;
        if (scan_last) begin
          scan_nxt     = '0;
          scan_row_nxt = '0;
          scan_col_nxt = '0;
          state_nxt    = S_SCAN;
        end else begin
          scan_nxt = scan_inc;
        end
      end
      S_SCAN: begin
        rd_addr      = scan_r[AW-1:0];
        walk_row_nxt = scan_row_r;
        walk_col_nxt = scan_col_r;
        walk_idx_nxt = scan_r[AW-1:0];
        first_nxt    = 1'b1;
        state_nxt    = S_WALK;
      end
      S_WALK, S_REWALK: begin
        // The read data in color_q and dir_q belong to the walk position.
        priority if ((state_r == S_WALK && first_r && color_q != COLOR_FREE) ||
                     (state_r == S_REWALK && color_q != COLOR_VISITING)) begin
          if (scan_last) begin
            res_valid_nxt = 1'b1;
            res_cycle_nxt = 1'b0;
            state_nxt     = S_IDLE;
          end else begin
            scan_nxt     = scan_inc;
            scan_col_nxt = scan_row_end ? '0 : scan_col_inc;
            scan_row_nxt = scan_row_end ? scan_row_inc : scan_row_r;
            state_nxt    = S_SCAN;
          end
        end else if (state_r == S_WALK && color_q == COLOR_VISITING) begin
          res_valid_nxt = 1'b1;
          res_cycle_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else if (state_r == S_WALK && color_q == COLOR_DONE) begin
          walk_row_nxt = scan_row_r;
          walk_col_nxt = scan_col_r;
          walk_idx_nxt = scan_r[AW-1:0];
          state_nxt    = S_REWALK_RD;
        end else begin
          color_we  = 1'b1;
          color_wd  = (state_r == S_WALK) ? COLOR_VISITING : COLOR_DONE;
          first_nxt = 1'b0;
          if (step_ok) begin
            walk_row_nxt = step_row;
            walk_col_nxt = step_col;
            walk_idx_nxt = step_idx;
            rd_addr      = step_idx;
          end else if (state_r == S_WALK) begin
            walk_row_nxt = scan_row_r;
            walk_col_nxt = scan_col_r;
            walk_idx_nxt = scan_r[AW-1:0];
            state_nxt    = S_REWALK_RD;
          end else if (scan_last) begin
            res_valid_nxt = 1'b1;
            res_cycle_nxt = 1'b0;
            state_nxt     = S_IDLE;
          end else begin
            scan_nxt     = scan_inc;
            scan_col_nxt = scan_row_end ? '0 : scan_col_inc;
            scan_row_nxt = scan_row_end ? scan_row_inc : scan_row_r;
            state_nxt    = S_SCAN;
          end
        end
      end
      S_REWALK_RD: begin
        state_nxt = S_REWALK;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rows_r      <= '0;
      cols_r      <= '0;
      total_r     <= '0;
      scan_r      <= '0;
      scan_row_r  <= '0;
      scan_col_r  <= '0;
      walk_row_r  <= '0;
      walk_col_r  <= '0;
      walk_idx_r  <= '0;
      first_r     <= 1'b0;
      res_valid_r <= 1'b0;
      res_cycle_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rows_r      <= rows_nxt;
      cols_r      <= cols_nxt;
      total_r     <= total_nxt;
      scan_r      <= scan_nxt;
      scan_row_r  <= scan_row_nxt;
      scan_col_r  <= scan_col_nxt;
      walk_row_r  <= walk_row_nxt;
      walk_col_r  <= walk_col_nxt;
      walk_idx_r  <= walk_idx_nxt;
      first_r     <= first_nxt;
      res_valid_r <= res_valid_nxt;
      res_cycle_r <= res_cycle_nxt;
    end
  end

  // A step always moves to another cell, so a write made with a step never meets
  // a read of the same entry at once; writes land before the next read is taken.
  always_ff @(posedge clk) begin
    if (color_we) begin
      color_mem[color_wa] <= color_wd;
    end
    color_q <= color_mem[rd_addr];
  end

  assign busy             = (state_r != S_IDLE);
  assign result.valid     = res_valid_r;
  assign result.has_cycle = res_cycle_r;

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r |-> $past(state_r) != S_IDLE)
    else $error("result strobe without detection work");

  a_step_not_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (color_we && (state_r == S_WALK || state_r == S_REWALK) && step_ok) |->
      rd_addr != color_wa)
    else $error("color read and write hit the same entry");

  a_walk_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK || state_r == S_REWALK) |->
      (walk_row_r < rows_r && walk_col_r < cols_r))
    else $error("walk position left the grid");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN || state_r == S_CLEAR) |-> scan_r < total_r)
    else $error("scan position beyond grid size");

endmodule

@@ rtl/core/grid_pointer_cycle_detect.sv @@
// Grid pointer cycle detector. Cells load one per cycle while busy is low.
// After the last cell, busy stays high while the walker clears the color store,
// scans the cells and walks and retraces each pointer chain, paced by the single
// color memory port; then has_cycle appears with a one-cycle out_valid strobe.
// Synchronous reset clears control and configuration; stores are not cleared.
module grid_pointer_cycle_detect (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [gpcd_pkg::DW-1:0] in_direction,
  input  logic                    in_last_cell,
  output logic                    out_valid,
  output logic                    out_has_cycle,
  input  logic                    cfg_we,
  input  logic                    cfg_index,
  input  logic [gpcd_pkg::CW-1:0] cfg_wdata
);
  import gpcd_pkg::*;

  logic [CW-1:0] row_count_r, row_count_nxt;
  logic [CW-1:0] column_count_r, column_count_nxt;
  logic          accept;
  logic          walker_busy;
  logic [AW-1:0] rd_addr;
  logic [DW-1:0] dir_q;
  gpcd_load_t    load;
  gpcd_launch_t  launch;
  gpcd_result_t  result;

  always_comb begin
    row_count_nxt    = row_count_r;
    column_count_nxt = column_count_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROW_COUNT:    row_count_nxt    = cfg_wdata;
        CFG_COLUMN_COUNT: column_count_nxt = cfg_wdata;
        default:          row_count_nxt    = row_count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r    <= '0;
      column_count_r <= '0;
    end else begin
      row_count_r    <= row_count_nxt;
      column_count_r <= column_count_nxt;
    end
  end

  // A request is taken when start is high and no detection is running.
  assign accept         = start && !walker_busy;
  assign load.accept    = accept;
  assign load.last      = in_last_cell;
  assign load.direction = in_direction;
  assign launch.launch  = accept && in_last_cell;
  assign launch.rows    = row_count_r;
  assign launch.cols    = column_count_r;

  gpcd_dir_store u_dir_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (load),
    .rd_addr (rd_addr),
    .rd_data (dir_q)
  );

  gpcd_walker u_walker (
    .clk     (clk),
    .rst_n   (rst_n),
    .launch  (launch),
    .dir_q   (dir_q),
    .rd_addr (rd_addr),
    .busy    (walker_busy),
    .result  (result)
  );

  assign busy          = walker_busy;
  assign out_valid     = result.valid;
  assign out_has_cycle = result.has_cycle;

endmodule

@@ sim/tb_grid_pointer_cycle_detect.sv @@
// Self-checking testbench for grid_pointer_cycle_detect: feeds grids cell by
// cell, predicts the cycle flag of each grid and checks every out_valid strobe.
// Depends on gpcd_pkg and the grid_pointer_cycle_detect top level.
module tb_grid_pointer_cycle_detect;
  import gpcd_pkg::*;

  localparam logic [DW-1:0] DIR_EXIT_LO  = 3'd4;
  localparam logic [DW-1:0] DIR_EXIT_HI  = 3'd7;
  localparam int            LIMIT        = 1_000_000;
  localparam int            RANDOM_CELLS = 1870;

  typedef enum int {MIX_ANY, MIX_POINTERS, MIX_ACYCLIC} mix_t;

  class cycle_scoreboard;
    logic [DW-1:0] cell_dir [DEPTH];
    logic [1:0]    color [DEPTH];
    logic [CW-1:0] rows_reg;
    logic [CW-1:0] cols_reg;
    int unsigned   load_pos;
    int unsigned   filled;
    int unsigned   here_row;
    int unsigned   here_col;
    bit            expected_flags [$];
    int            errors;
    int            grids;
    int            loops_seen;

    function new();
      rows_reg   = '0;
      cols_reg   = '0;
      load_pos   = 0;
      filled     = 0;
      errors     = 0;
      grids      = 0;
      loops_seen = 0;
    endfunction

    function void write_reg(logic idx, logic [CW-1:0] value);
      if (idx == CFG_ROW_COUNT) begin
        rows_reg = value;
      end else begin
        cols_reg = value;
      end
    endfunction

    function int pending();
      return expected_flags.size();
    endfunction

    // Moves the walk one cell along its pointer; 0 means it left the grid.
    function bit advance(int unsigned nr, int unsigned nc);
      logic [DW-1:0] d;
      bit            ok;
      d  = cell_dir[here_row * nc + here_col];
      ok = 1'b1;
      case (d)
        DIR_LEFT: begin
          if (here_col == 0) ok = 1'b0;
          else here_col = here_col - 1;
        end
        DIR_RIGHT: begin
          if (here_col + 1 >= nc) ok = 1'b0;
          else here_col = here_col + 1;
        end
        DIR_UP: begin
          if (here_row == 0) ok = 1'b0;
          else here_row = here_row - 1;
        end
        DIR_DOWN: begin
          if (here_row + 1 >= nr) ok = 1'b0;
          else here_row = here_row + 1;
        end
        default: ok = 1'b0;
      endcase
      return ok;
    endfunction

    function bit find_loop();
      int unsigned nr;
      int unsigned nc;
      int unsigned total;
      int unsigned pos;
      bit          hit;
      bit          moving;
      nr    = (rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg;
      nc    = (cols_reg > MAX_COLS) ? MAX_COLS : cols_reg;
      total = nr * nc;
      hit   = 1'b0;
      for (int i = 0; i < DEPTH; i++) color[i] = COLOR_FREE;
      for (pos = 0; pos < total && !hit; pos++) begin
        if (color[pos] == COLOR_FREE) begin
          here_row = pos / nc;
          here_col = pos % nc;
          moving   = 1'b1;
          while (moving) begin
            if (color[here_row * nc + here_col] == COLOR_VISITING) begin
              hit    = 1'b1;
              moving = 1'b0;
            end else if (color[here_row * nc + here_col] == COLOR_DONE) begin
              moving = 1'b0;
            end else begin
              color[here_row * nc + here_col] = COLOR_VISITING;
              moving = advance(nr, nc);
            end
          end
          // Retrace the same path and retire its cells.
          here_row = pos / nc;
          here_col = pos % nc;
          moving   = 1'b1;
          while (moving) begin
            if (color[here_row * nc + here_col] != COLOR_VISITING) begin
              moving = 1'b0;
            end else begin
              color[here_row * nc + here_col] = COLOR_DONE;
              moving = advance(nr, nc);
            end
          end
        end
      end
      return hit;
    endfunction

    function void note_cell(logic [DW-1:0] dir, logic last);
      // Cells past the end of the store are dropped.
      if (load_pos < DEPTH) begin
        cell_dir[load_pos] = dir;
        load_pos = load_pos + 1;
        if (load_pos > filled) filled = load_pos;
      end
      if (last) begin
        expected_flags.push_back(find_loop());
        load_pos = 0;
      end
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(logic got);
      bit want;
      if (expected_flags.size() == 0) begin
        report($sformatf("has_cycle=%b with no request pending", got));
      end else begin
        want = expected_flags.pop_front();
        grids++;
        if (want) loops_seen++;
        if (got !== want) begin
          report($sformatf("grid %0d: has_cycle=%b, predicted %b", grids, got, want));
        end
      end
    endtask
  endclass

  logic          clk          = 1'b0;
  logic          rst_n        = 1'b0;
  logic          start        = 1'b0;
  logic [DW-1:0] in_direction = '0;
  logic          in_last_cell = 1'b0;
  logic          cfg_we       = 1'b0;
  logic          cfg_index    = CFG_ROW_COUNT;
  logic [CW-1:0] cfg_wdata    = '0;
  logic          busy;
  logic          out_valid;
  logic          out_has_cycle;

  cycle_scoreboard sb;
  int unsigned     items_sent = 0;
  bit              quiet      = 1'b0;

  grid_pointer_cycle_detect uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_direction (in_direction),
    .in_last_cell (in_last_cell),
    .out_valid    (out_valid),
    .out_has_cycle(out_has_cycle),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (LIMIT) @(posedge clk);
    $display("grid_pointer_cycle_detect regression: fail");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_has_cycle);
  end

  function automatic logic [DW-1:0] pick_dir(mix_t mix);
    logic [DW-1:0] d;
    case (mix)
      MIX_POINTERS: begin
        if ($urandom_range(0, 9) == 0) d = DW'($urandom_range(DIR_EXIT_LO, DIR_EXIT_HI));
        else d = DW'($urandom_range(DIR_LEFT, DIR_DOWN));
      end
      MIX_ACYCLIC: begin
        // Only right, down or exit: every chain is monotone, so no cycle.
        case ($urandom_range(0, 4))
          0, 1:    d = DIR_RIGHT;
          2, 3:    d = DIR_DOWN;
          default: d = DW'($urandom_range(DIR_EXIT_LO, DIR_EXIT_HI));
        endcase
      end
      default: d = DW'($urandom_range(DIR_LEFT, DIR_EXIT_HI));
    endcase
    return d;
  endfunction

  function automatic int unsigned cells_of(int unsigned r, int unsigned c);
    return ((r > MAX_ROWS) ? MAX_ROWS : r) * ((c > MAX_COLS) ? MAX_COLS : c);
  endfunction

  task send_cell(logic [DW-1:0] dir, logic last);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_direction <= dir;
    in_last_cell <= last;
    start        <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_cell(dir, last);
    items_sent++;
    // Keep the block from taking a stale request once detection finishes.
    if (last) start <= 1'b0;
  endtask

  task begin_grid(logic [CW-1:0] r, logic [CW-1:0] c);
    while (sb.pending() != 0 || busy) @(posedge clk);
    repeat ($urandom_range(0, 4)) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ROW_COUNT;
    cfg_wdata <= r;
    @(posedge clk);
    sb.write_reg(CFG_ROW_COUNT, r);
    cfg_index <= CFG_COLUMN_COUNT;
    cfg_wdata <= c;
    @(posedge clk);
    sb.write_reg(CFG_COLUMN_COUNT, c);
    cfg_we <= 1'b0;
  endtask

  task send_grid(int unsigned count, mix_t mix);
    for (int unsigned i = 0; i < count; i++) send_cell(pick_dir(mix), i == count - 1);
  endtask

  initial begin
    int unsigned r;
    int unsigned c;
    int unsigned total;
    int unsigned count;
    int unsigned sel;
    int unsigned rand_from;
    mix_t        mix;

    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Dimensions come out of reset as zero, so the first grid is empty.
    send_cell(DIR_DOWN, 1'b1);
    begin_grid(1, 1);
    send_cell(DIR_LEFT, 1'b1);
    begin_grid(1, 1);
    send_cell(DIR_UP, 1'b1);
    begin_grid(1, 2);
    send_cell(DIR_RIGHT, 1'b0);
    send_cell(DIR_LEFT, 1'b1);
    begin_grid(2, 1);
    send_cell(DIR_DOWN, 1'b0);
    send_cell(DIR_UP, 1'b1);
    begin_grid(2, 2);
    send_cell(DIR_RIGHT, 1'b0);
    send_cell(DIR_DOWN, 1'b0);
    send_cell(DIR_UP, 1'b0);
    send_cell(DIR_LEFT, 1'b1);
    begin_grid(2, 2);
    for (int k = 0; k < 4; k++) send_cell(DW'(DIR_EXIT_LO + k), k == 3);
    begin_grid(1, 3);
    send_cell(DIR_RIGHT, 1'b0);
    send_cell(DIR_RIGHT, 1'b0);
    send_cell(DIR_DOWN, 1'b1);
    begin_grid(3, 0);
    send_cell(DIR_LEFT, 1'b0);
    send_cell(DIR_LEFT, 1'b1);
    // A short grid: the remaining cells keep what earlier grids stored.
    begin_grid(2, 2);
    send_cell(DIR_RIGHT, 1'b1);
    begin_grid(0, 127);
    send_cell(DIR_RIGHT, 1'b1);

    rand_from = items_sent;
    while (items_sent - rand_from < RANDOM_CELLS) begin
      sel = $urandom_range(0, 99);
      if (sel < 5) begin
        r = 0;
        c = $urandom_range(0, 127);
        if ($urandom_range(0, 1)) begin
          r = c;
          c = 0;
        end
      end else if (sel < 85) begin
        r = $urandom_range(1, 8);
        c = $urandom_range(1, 8);
      end else if (sel < 96) begin
        r = $urandom_range(1, 20);
        c = $urandom_range(1, 20);
      end else begin
        r = $urandom_range(64, 127);
        c = $urandom_range(1, 2);
        if ($urandom_range(0, 1)) begin
          c = r;
          r = $urandom_range(1, 2);
        end
      end
      total = cells_of(r, c);
      sel   = $urandom_range(0, 99);
      if (total == 0) count = $urandom_range(1, 3);
      else if (sel < 10 && sb.filled >= total) count = $urandom_range(1, total);
      else if (sel < 18) count = total + $urandom_range(1, 4);
      else count = total;
      mix   = mix_t'($urandom_range(0, 2));
      quiet = ($urandom_range(0, 3) == 0);
      begin_grid(CW'(r), CW'(c));
      send_grid(count, mix);
    end

    while (sb.pending() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("checked %0d grids, %0d of them with a cycle, from %0d cell requests",
             sb.grids, sb.loops_seen, items_sent);
    $display("dimensions ran from empty through saturated, with short and overlong grids");
    if (sb.errors == 0) begin
      $display("grid_pointer_cycle_detect regression: pass");
    end else begin
      $display("grid_pointer_cycle_detect regression: fail");
    end
    $finish;
  end
endmodule
